// ----- hw/rtl/svpwm_min_max_injection_top_macros.svh -----
// Assertion macros used by the checker file of this block.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef SVPWM_MIN_MAX_INJECTION_TOP_MACROS_SVH
`define SVPWM_MIN_MAX_INJECTION_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVPWM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVPWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/svpwm_mmi_pkg.sv -----
// ----------------------------------------------------------------------------
// SVPWM min-max injection package
// Shared widths, reset values, register indexes, transfer structs and
// fixed-point constant helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_mmi_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int DATA_W            = 32;
    localparam int DUTY_W            = 17;
    localparam int BUS_LIM_W         = 31;
    localparam int RATIO_W           = 17;

    localparam logic [BUS_LIM_W-1:0] BUS_LIM_RESET   = 31'd3932160;
    localparam logic [RATIO_W-1:0]   DUTY_RATIO_RESET = 17'd62259;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_BUS_LIMIT  = 1'b0,
        CFG_DUTY_RATIO = 1'b1
    } cfg_idx_t;

    // One queued item, already classified by the front end.
    typedef struct packed {
        logic signed [DATA_W-1:0] alpha;
        logic signed [DATA_W-1:0] beta;
        logic signed [DATA_W-1:0] bus;
        logic                     fault;
    } item_t;

    // One finished result.
    typedef struct packed {
        logic [DUTY_W-1:0]        duty_a;
        logic [DUTY_W-1:0]        duty_b;
        logic [DUTY_W-1:0]        duty_c;
        logic [DUTY_W-1:0]        duty_peak;
        logic                     bus_fault;
        logic                     was_limited;
        logic signed [DATA_W-1:0] limited_alpha;
        logic signed [DATA_W-1:0] limited_beta;
    } result_t;

    // sqrt(3)/2 rounded to nearest at f fraction bits.
    function automatic logic [31:0] q_sqrt3_2(input int f);
        logic [63:0] sum;
        logic [63:0] sh;
        sum = 64'd3719550787 + (64'd1 << (31 - f));
        sh  = sum >> (32 - f);
        return sh[31:0];
    endfunction

    // 1/sqrt(3) rounded to nearest at f fraction bits.
    function automatic logic [31:0] q_inv_sqrt3(input int f);
        logic [63:0] sum;
        logic [63:0] sh;
        sum = 64'd2479700525 + (64'd1 << (31 - f));
        sh  = sum >> (32 - f);
        return sh[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/svpwm_mmi_front.sv -----
// ----------------------------------------------------------------------------
// SVPWM front end
// Holds the configuration registers, accepts items, flags bus faults and
// keeps a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_mmi_front (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   volt_alpha,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   volt_beta,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   bus_voltage,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [0:0]                                cfg_index,
    input  wire logic [svpwm_mmi_pkg::DATA_W-1:0]          cfg_data,
    output logic                                           q_valid,
    output svpwm_mmi_pkg::item_t                           q_item,
    input  wire logic                                      q_take,
    output logic [svpwm_mmi_pkg::RATIO_W-1:0]              limit_ratio
);

    logic [svpwm_mmi_pkg::BUS_LIM_W-1:0] bus_lim_reg;
    logic [svpwm_mmi_pkg::RATIO_W-1:0]   ratio_reg;
    svpwm_mmi_pkg::item_t                slot_reg [2];
    logic                                wr_ptr_reg;
    logic                                rd_ptr_reg;
    logic [1:0]                          count_reg;
    logic [1:0]                          count_next;
    logic                                push;
    logic                                pop;
    logic                                fault;
    svpwm_mmi_pkg::item_t                new_item;

    assign cfg_ready   = 1'b1;
    assign limit_ratio = ratio_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_lim_reg <= svpwm_mmi_pkg::BUS_LIM_RESET;
            ratio_reg   <= svpwm_mmi_pkg::DUTY_RATIO_RESET;
        end
        else if (cfg_valid)
        begin
            case (svpwm_mmi_pkg::cfg_idx_t'(cfg_index))
                svpwm_mmi_pkg::CFG_BUS_LIMIT:
                    bus_lim_reg <= cfg_data[svpwm_mmi_pkg::BUS_LIM_W-1:0];
                svpwm_mmi_pkg::CFG_DUTY_RATIO:
                    ratio_reg <= cfg_data[svpwm_mmi_pkg::RATIO_W-1:0];
                default:
                    bus_lim_reg <= bus_lim_reg;
            endcase
        end
    end

    // A bus that is not positive or above the limit is a fault.
    assign fault = bus_voltage[31] || (bus_voltage == '0)
                   || (bus_voltage[30:0] > bus_lim_reg);

    always_comb
    begin
        new_item.alpha = volt_alpha;
        new_item.beta  = volt_beta;
        new_item.bus   = bus_voltage;
        new_item.fault = fault;
    end

    // Queue bookkeeping.
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_take && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Queue payload.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/svpwm_mmi_div.sv -----
// ----------------------------------------------------------------------------
// SVPWM power-of-two divider
// Restoring long division of 2^exp_bits by a positive 32-bit divisor, one
// quotient bit per cycle, with a sticky flag once the quotient reaches 2^62.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_mmi_div #(
    parameter int FRAC_BITS = svpwm_mmi_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [$clog2(3*FRAC_BITS+1)-1:0]      exp_bits,
    input  wire logic [31:0]                           den,
    output logic [62:0]                                quot,
    output logic                                       sat,
    output logic                                       done
);

    localparam int EW = $clog2(3*FRAC_BITS+1);

    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [62:0]   quot_reg;
    logic          sat_reg;
    logic [EW-1:0] cnt_reg;
    logic          first_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [32:0]   rem_sh;
    logic          ge;
    logic [32:0]   rem_next;
    logic [62:0]   quot_next;

    // One restoring step; the dividend has a single one at its top bit.
    always_comb
    begin
        rem_sh    = {rem_reg, first_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        rem_next  = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        quot_next = {quot_reg[61:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            sat_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                first_reg <= 1'b1;
                sat_reg   <= 1'b0;
                cnt_reg   <= exp_bits;
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                sat_reg   <= sat_reg | quot_next[62];
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next[31:0];
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/svpwm_mmi_sqrt.sv -----
// ----------------------------------------------------------------------------
// SVPWM integer square root
// Floor square root of a 62-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_mmi_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [61:0] rad,
    output logic [30:0]      root,
    output logic             done
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        ge;
    logic [63:0] v_next;
    logic [63:0] r_next;

    // One digit-by-digit step.
    always_comb
    begin
        trial  = r_reg + bit_reg;
        ge     = (v_reg >= trial);
        v_next = ge ? (v_reg - trial) : v_reg;
        r_next = ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= {2'b00, rad};
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = r_reg[30:0];
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/svpwm_mmi_back.sv -----
// ----------------------------------------------------------------------------
// SVPWM back end
// Sequencer around one shared multiplier, the divider and the square root
// unit: vector limiting, inverse Clarke, bus normalization, min-max
// injection, clipping and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_mmi_back #(
    parameter int FRAC_BITS = svpwm_mmi_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_valid,
    input  wire svpwm_mmi_pkg::item_t                q_item,
    output logic                                     q_take,
    input  wire logic [svpwm_mmi_pkg::RATIO_W-1:0]   limit_ratio,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output svpwm_mmi_pkg::result_t                   result
);

    localparam int EW = $clog2(3*FRAC_BITS+1);
    localparam logic signed [31:0] K_ONE      = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] K_HALF     = 32'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] K_NHALF    = -K_HALF;
    localparam logic signed [31:0] K_SQRT3_2  = svpwm_mmi_pkg::q_sqrt3_2(FRAC_BITS);
    localparam logic signed [31:0] K_NSQRT3_2 = -K_SQRT3_2;
    localparam logic signed [31:0] K_INV_SQ3  = svpwm_mmi_pkg::q_inv_sqrt3(FRAC_BITS);
    localparam logic signed [31:0] K_MAXPOS   = 32'sh7FFF_FFFF;
    localparam logic [EW-1:0]      EXP_RECIP  = EW'(2*FRAC_BITS);
    localparam logic [EW-1:0]      EXP_ISQRT  = EW'(3*FRAC_BITS);

    typedef enum logic [4:0] {
        S_IDLE, S_AA, S_BB, S_LT, S_LR, S_LSQ, S_CMP, S_IDIV, S_ISQ,
        S_SC, S_SA, S_SB, S_RDIV, S_HA, S_VA, S_S1, S_VB, S_S2, S_VC,
        S_MM, S_OFF, S_DUTY, S_PEAK
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic signed [31:0]      a_reg;
    logic signed [31:0]      b_reg;
    logic signed [31:0]      bus_reg;
    logic                    fault_reg;
    logic                    limited_reg;
    logic signed [31:0]      mag_reg;
    logic signed [31:0]      lim_reg;
    logic signed [31:0]      isq_reg;
    logic signed [31:0]      ib_reg;
    logic signed [31:0]      ha_reg;
    logic signed [31:0]      tmp_reg;
    logic signed [31:0]      va_reg;
    logic signed [31:0]      vb_reg;
    logic signed [31:0]      vc_reg;
    logic                    out_valid_reg;
    svpwm_mmi_pkg::result_t  out_reg;

    logic signed [31:0]      mul_x;
    logic signed [31:0]      mul_y;
    logic signed [63:0]      mul_full;
    logic signed [31:0]      mul_res;
    logic                    over;
    logic                    mag_pos;
    logic                    div_start;
    logic [EW-1:0]           div_exp;
    logic [31:0]             div_den;
    logic [62:0]             div_quot;
    logic                    div_sat;
    logic                    div_done;
    logic                    sqrt_start;
    logic [30:0]             sqrt_root;
    logic                    sqrt_done;
    logic signed [31:0]      mn;
    logic signed [31:0]      mx;
    logic signed [31:0]      pk;
    logic                    out_free;
    svpwm_mmi_pkg::result_t  res_next;

    // Clip a duty to the range zero to one.
    function automatic logic signed [31:0] clip01(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > K_ONE)
        begin
            r = K_ONE;
        end
        return r;
    endfunction

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_x = a_reg;
        mul_y = a_reg;
        case (state_reg)
            S_AA:  begin mul_x = a_reg;      mul_y = a_reg;   end
            S_BB:  begin mul_x = b_reg;      mul_y = b_reg;   end
            S_LT:  begin mul_x = bus_reg;    mul_y = K_INV_SQ3; end
            S_LR:  begin mul_x = lim_reg;    mul_y = 32'($unsigned(limit_ratio)); end
            S_LSQ: begin mul_x = lim_reg;    mul_y = lim_reg; end
            S_SC:  begin mul_x = lim_reg;    mul_y = isq_reg; end
            S_SA:  begin mul_x = a_reg;      mul_y = tmp_reg; end
            S_SB:  begin mul_x = b_reg;      mul_y = tmp_reg; end
            S_HA:  begin mul_x = K_NHALF;    mul_y = a_reg;   end
            S_VA:  begin mul_x = a_reg;      mul_y = ib_reg;  end
            S_S1:  begin mul_x = K_SQRT3_2;  mul_y = b_reg;   end
            S_VB:  begin mul_x = tmp_reg;    mul_y = ib_reg;  end
            S_S2:  begin mul_x = K_NSQRT3_2; mul_y = b_reg;   end
            S_VC:  begin mul_x = tmp_reg;    mul_y = ib_reg;  end
            S_OFF: begin mul_x = tmp_reg;    mul_y = K_NHALF; end
            default: begin mul_x = a_reg;    mul_y = a_reg;   end
        endcase
    end

    assign mul_full = mul_x * mul_y;
    assign mul_res  = mul_full[FRAC_BITS +: 32];

    // Limit test and unit starts.
    assign over    = (mag_reg > tmp_reg);
    assign mag_pos = !mag_reg[31] && (mag_reg != '0);

    always_comb
    begin
        div_start = 1'b0;
        div_exp   = EXP_RECIP;
        div_den   = bus_reg;
        if (state_reg == S_CMP)
        begin
            if (over)
            begin
                div_start = mag_pos;
                div_exp   = EXP_ISQRT;
                div_den   = mag_reg;
            end
            else
            begin
                div_start = 1'b1;
            end
        end
        else if (state_reg == S_SB)
        begin
            div_start = 1'b1;
        end
    end

    assign sqrt_start = (state_reg == S_IDIV) && div_done && !div_sat;

    // Min and max of the three normalized phases.
    always_comb
    begin
        mn = (va_reg < vb_reg) ? va_reg : vb_reg;
        mn = (vc_reg < mn) ? vc_reg : mn;
        mx = (va_reg > vb_reg) ? va_reg : vb_reg;
        mx = (vc_reg > mx) ? vc_reg : mx;
        pk = (vb_reg > vc_reg) ? vb_reg : vc_reg;
        pk = (va_reg > pk) ? va_reg : pk;
    end

    // Result assembly.
    assign out_free = !out_valid_reg || out_ready;
    always_comb
    begin
        res_next.duty_a        = va_reg[svpwm_mmi_pkg::DUTY_W-1:0];
        res_next.duty_b        = vb_reg[svpwm_mmi_pkg::DUTY_W-1:0];
        res_next.duty_c        = vc_reg[svpwm_mmi_pkg::DUTY_W-1:0];
        res_next.duty_peak     = pk[svpwm_mmi_pkg::DUTY_W-1:0];
        res_next.bus_fault     = 1'b0;
        res_next.was_limited   = limited_reg;
        res_next.limited_alpha = a_reg;
        res_next.limited_beta  = b_reg;
        if (fault_reg)
        begin
            res_next               = '0;
            res_next.bus_fault     = 1'b1;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        q_take     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_take     = 1'b1;
                    state_next = q_item.fault ? S_PEAK : S_AA;
                end
            end
            S_AA:   state_next = S_BB;
            S_BB:   state_next = S_LT;
            S_LT:   state_next = S_LR;
            S_LR:   state_next = S_LSQ;
            S_LSQ:  state_next = S_CMP;
            S_CMP:
            begin
                if (!over)
                begin
                    state_next = S_RDIV;
                end
                else if (mag_pos)
                begin
                    state_next = S_IDIV;
                end
                else
                begin
                    state_next = S_SC;
                end
            end
            S_IDIV:
            begin
                if (div_done)
                begin
                    state_next = div_sat ? S_SC : S_ISQ;
                end
            end
            S_ISQ:
            begin
                if (sqrt_done)
                begin
                    state_next = S_SC;
                end
            end
            S_SC:   state_next = S_SA;
            S_SA:   state_next = S_SB;
            S_SB:   state_next = S_RDIV;
            S_RDIV:
            begin
                if (div_done)
                begin
                    state_next = S_HA;
                end
            end
            S_HA:   state_next = S_VA;
            S_VA:   state_next = S_S1;
            S_S1:   state_next = S_VB;
            S_VB:   state_next = S_S2;
            S_S2:   state_next = S_VC;
            S_VC:   state_next = S_MM;
            S_MM:   state_next = S_OFF;
            S_OFF:  state_next = S_DUTY;
            S_DUTY: state_next = S_PEAK;
            S_PEAK:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State, output handshake and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_PEAK) && out_free)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= res_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                a_reg       <= q_item.alpha;
                b_reg       <= q_item.beta;
                bus_reg     <= q_item.bus;
                fault_reg   <= q_item.fault;
                limited_reg <= 1'b0;
            end
            S_AA:  mag_reg <= mul_res;
            S_BB:  mag_reg <= mag_reg + mul_res;
            S_LT:  lim_reg <= mul_res;
            S_LR:  lim_reg <= mul_res;
            S_LSQ: tmp_reg <= mul_res;
            S_CMP:
            begin
                limited_reg <= over;
                isq_reg     <= K_MAXPOS;
            end
            S_IDIV:
            begin
                isq_reg <= K_MAXPOS;
            end
            S_ISQ:
            begin
                isq_reg <= {1'b0, sqrt_root};
            end
            S_SC:  tmp_reg <= mul_res;
            S_SA:  a_reg   <= mul_res;
            S_SB:  b_reg   <= mul_res;
            S_RDIV: ib_reg <= div_quot[31:0];
            S_HA:  ha_reg  <= mul_res;
            S_VA:  va_reg  <= mul_res;
            S_S1:  tmp_reg <= ha_reg + mul_res;
            S_VB:  vb_reg  <= mul_res;
            S_S2:  tmp_reg <= ha_reg + mul_res;
            S_VC:  vc_reg  <= mul_res;
            S_MM:  tmp_reg <= mn + mx;
            S_OFF: tmp_reg <= mul_res;
            S_DUTY:
            begin
                va_reg <= clip01(va_reg + tmp_reg + K_HALF);
                vb_reg <= clip01(vb_reg + tmp_reg + K_HALF);
                vc_reg <= clip01(vc_reg + tmp_reg + K_HALF);
            end
            default: tmp_reg <= tmp_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    svpwm_mmi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .exp_bits (div_exp),
        .den      (div_den),
        .quot     (div_quot),
        .sat      (div_sat),
        .done     (div_done)
    );

    svpwm_mmi_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (div_quot[61:0]),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/svpwm_min_max_injection_top.sv -----
// ----------------------------------------------------------------------------
// SVPWM min-max injection top level
// Space-vector duty generation by zero-sequence injection with vector
// limiting and bus fault detection.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------
//  input   | in_valid / in_ready   | volt_alpha, volt_beta, bus_voltage
//  output  | out_valid / out_ready | duty_a/b/c, duty_peak, flags, limited
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A faulted item goes straight to the result register; an unlimited one runs
//  through the bit-serial reciprocal divider; a limited one also takes the
//  inverse square root division and the 32-step root.
//  A two-entry queue accepts items until full while the back end works, and a
//  result register holds a finished result while the next item proceeds.
//  Reset is asynchronous and active low; config writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_min_max_injection_top #(
    parameter int FRAC_BITS = svpwm_mmi_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      in_valid,
    output logic                                           in_ready,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   volt_alpha,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   volt_beta,
    input  wire logic signed [svpwm_mmi_pkg::DATA_W-1:0]   bus_voltage,
    output logic                                           out_valid,
    input  wire logic                                      out_ready,
    output logic [svpwm_mmi_pkg::DUTY_W-1:0]               duty_a,
    output logic [svpwm_mmi_pkg::DUTY_W-1:0]               duty_b,
    output logic [svpwm_mmi_pkg::DUTY_W-1:0]               duty_c,
    output logic [svpwm_mmi_pkg::DUTY_W-1:0]               duty_peak,
    output logic                                           bus_fault,
    output logic                                           was_limited,
    output logic signed [svpwm_mmi_pkg::DATA_W-1:0]        limited_alpha,
    output logic signed [svpwm_mmi_pkg::DATA_W-1:0]        limited_beta,
    input  wire logic                                      cfg_valid,
    output logic                                           cfg_ready,
    input  wire logic [0:0]                                cfg_index,
    input  wire logic [svpwm_mmi_pkg::DATA_W-1:0]          cfg_data
);

    logic                                q_valid;
    logic                                q_take;
    svpwm_mmi_pkg::item_t                q_item;
    logic [svpwm_mmi_pkg::RATIO_W-1:0]   limit_ratio;
    svpwm_mmi_pkg::result_t              result;

    svpwm_mmi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .volt_alpha  (volt_alpha),
        .volt_beta   (volt_beta),
        .bus_voltage (bus_voltage),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .limit_ratio (limit_ratio)
    );

    svpwm_mmi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take),
        .limit_ratio (limit_ratio),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result)
    );

    // Result fields onto their ports.
    assign duty_a        = result.duty_a;
    assign duty_b        = result.duty_b;
    assign duty_c        = result.duty_c;
    assign duty_peak     = result.duty_peak;
    assign bus_fault     = result.bus_fault;
    assign was_limited   = result.was_limited;
    assign limited_alpha = result.limited_alpha;
    assign limited_beta  = result.limited_beta;

endmodule

`default_nettype wire

// ----- hw/rtl/svpwm_mmi_checker.sv -----
// ----------------------------------------------------------------------------
// SVPWM port checker
// Watches the top-level ports for result consistency and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "svpwm_min_max_injection_top_macros.svh"

module svpwm_mmi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [16:0] duty_a,
    input wire logic [16:0] duty_b,
    input wire logic [16:0] duty_c,
    input wire logic [16:0] duty_peak,
    input wire logic        bus_fault,
    input wire logic        was_limited,
    input wire logic [31:0] limited_alpha,
    input wire logic [31:0] limited_beta
);

    logic duties_zero;
    logic vector_zero;
    logic peak_hit;
    logic peak_in_range;
    logic peak_ge_a;

    // Helper terms that keep the assertions short.
    assign duties_zero   = (duty_a == '0) && (duty_b == '0) && (duty_c == '0)
                           && (duty_peak == '0);
    assign vector_zero   = !was_limited && (limited_alpha == '0) && (limited_beta == '0);
    assign peak_hit      = (duty_peak == duty_a) || (duty_peak == duty_b)
                           || (duty_peak == duty_c);
    assign peak_in_range = !bus_fault && (duty_peak <= 17'h10000);
    assign peak_ge_a     = (duty_peak >= duty_a) || (duty_a > 17'h10000);

    // A stalled result stays offered.
    `SVPWM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // A faulted result carries all zeros.
    `SVPWM_ASSERT_NOW(a_fault_zero, out_valid && bus_fault, duties_zero && vector_zero, "fault result not cleared")

    // The peak is one of the three phase duties.
    `SVPWM_ASSERT_NOW(a_peak_member, out_valid, peak_hit, "peak duty matches no phase")

    // The peak is never below phase A at the default format.
    `SVPWM_ASSERT_NOW(a_peak_max, out_valid && peak_in_range, peak_ge_a, "peak below phase A")

endmodule

bind svpwm_min_max_injection_top svpwm_mmi_checker u_chk (.*);

`default_nettype wire
